>>> rtl/uart_dual_byte_fifo_defines.svh
// ---------------------------------------------------------------------------
// UART dual byte FIFO assertion macros
// Shared property wrappers for the checker, sampled on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef UART_DUAL_BYTE_FIFO_DEFINES_SVH
`define UART_DUAL_BYTE_FIFO_DEFINES_SVH

// Checked only outside reset.
`define UDBF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("udbf assertion failed");

// Checked in every cycle, reset included.
`define UDBF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("udbf assertion failed");

`endif

>>> rtl/udbf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART dual byte FIFO package
// Word types, event and status codes and default sizes shared by the block.
// ---------------------------------------------------------------------------
package udbf_pkg;

   localparam int FIFO_DEPTH_DEF = 128;
   localparam int DATA_W         = 8;
   localparam int LEVEL_W        = 8;

   localparam logic [1:0] EV_LINE_RX = 2'd0;
   localparam logic [1:0] EV_LINE_TX = 2'd1;
   localparam logic [1:0] EV_HOST_RD = 2'd2;
   localparam logic [1:0] EV_HOST_WR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DATA_W-1:0] data_in;
   } udbf_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic [1:0]         status;
      logic               overflow_seen;
      logic               rx_irq_enabled;
      logic               tx_irq_enabled;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
   } udbf_rsp_type;

endpackage

>>> rtl/udbf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART dual byte FIFO RAM
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module udbf_ram #(
   parameter int WIDTH = udbf_pkg::DATA_W,
   parameter int DEPTH = udbf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/uart_dual_byte_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART dual byte FIFO
// Receive and transmit byte ring FIFOs between a serial line and a host.
// ---------------------------------------------------------------------------
// Each request word carries one event: a line byte received, the line asking
// for a byte, a host read or a host write. Every request yields exactly one
// response word with the popped byte, a status code, the overflow and
// interrupt enable flags and both FIFO levels after the event.
// Both FIFOs live in RAMs with a registered read. Indices, counts
// and flags are updated at acceptance, so the next event sees them at once.
// After acceptance a response passes the RAM read stage, then the output
// register. One request is taken per cycle while req_stall stays low.
// When the response side stalls, the output register holds its word and one
// more event waits in the read stage; after that req_stall goes high.
// Reset empties both FIFOs, clears the overflow flag and the transmit
// interrupt enable and sets the receive interrupt enable. RAM contents are
// not cleared; only written entries are ever read.
// ---------------------------------------------------------------------------
module uart_dual_byte_fifo #(
   parameter int FIFO_DEPTH = udbf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  udbf_pkg::udbf_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output udbf_pkg::udbf_rsp_type rsp_data
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);

   logic [AW-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [AW-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [FW-1:0] rx_fill_ff, rx_fill_in, tx_fill_ff, tx_fill_in;
   logic          overflow_ff, overflow_in;
   logic          rx_irq_ff, rx_irq_in;
   logic          tx_irq_ff, tx_irq_in;

   logic                   pend_ff, pend_in;
   logic                   pend_pop_ff, pend_pop_in;
   logic                   pend_tx_ff, pend_tx_in;
   udbf_pkg::udbf_rsp_type pend_rsp_ff, pend_rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   udbf_pkg::udbf_rsp_type rsp_data_ff, rsp_data_in;

   logic                          accept, advance;
   logic                          rx_we, rx_re, tx_we, tx_re;
   logic [1:0]                    status;
   logic [udbf_pkg::DATA_W-1:0]   rx_q, tx_q;

   assign advance   = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rx_wr_in    = rx_wr_ff;
      rx_rd_in    = rx_rd_ff;
      rx_fill_in  = rx_fill_ff;
      tx_wr_in    = tx_wr_ff;
      tx_rd_in    = tx_rd_ff;
      tx_fill_in  = tx_fill_ff;
      overflow_in = overflow_ff;
      rx_irq_in   = rx_irq_ff;
      tx_irq_in   = tx_irq_ff;
      rx_we       = 1'b0;
      rx_re       = 1'b0;
      tx_we       = 1'b0;
      tx_re       = 1'b0;
      pend_pop_in = 1'b0;
      pend_tx_in  = 1'b0;
      status      = udbf_pkg::ST_OK;
      if (accept) begin
         unique case (req_data.req_type)
            udbf_pkg::EV_LINE_RX: begin
               if (rx_fill_ff == FW'(FIFO_DEPTH)) begin
                  overflow_in = 1'b1;
                  rx_irq_in   = 1'b0;
                  status      = udbf_pkg::ST_FULL;
               end else begin
                  rx_we      = 1'b1;
                  rx_wr_in   = (rx_wr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rx_wr_ff + 1'b1;
                  rx_fill_in = rx_fill_ff + 1'b1;
               end
            end
            udbf_pkg::EV_LINE_TX: begin
               if (tx_fill_ff == '0) begin
                  tx_irq_in = 1'b0;
                  status    = udbf_pkg::ST_EMPTY;
               end else begin
                  tx_re       = 1'b1;
                  pend_pop_in = 1'b1;
                  pend_tx_in  = 1'b1;
                  tx_rd_in    = (tx_rd_ff == AW'(FIFO_DEPTH - 1)) ? '0 : tx_rd_ff + 1'b1;
                  tx_fill_in  = tx_fill_ff - 1'b1;
               end
            end
            udbf_pkg::EV_HOST_RD: begin
               if (rx_fill_ff == '0) begin
                  status = udbf_pkg::ST_EMPTY;
               end else begin
                  rx_re       = 1'b1;
                  pend_pop_in = 1'b1;
                  rx_rd_in    = (rx_rd_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rx_rd_ff + 1'b1;
                  rx_fill_in  = rx_fill_ff - 1'b1;
               end
            end
            udbf_pkg::EV_HOST_WR: begin
               if (tx_fill_ff == FW'(FIFO_DEPTH)) begin
                  status = udbf_pkg::ST_FULL;
               end else begin
                  tx_we      = 1'b1;
                  tx_irq_in  = 1'b1;
                  tx_wr_in   = (tx_wr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : tx_wr_ff + 1'b1;
                  tx_fill_in = tx_fill_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      pend_rsp_in.data_out       = '0;
      pend_rsp_in.status         = status;
      pend_rsp_in.overflow_seen  = overflow_in;
      pend_rsp_in.rx_irq_enabled = rx_irq_in;
      pend_rsp_in.tx_irq_enabled = tx_irq_in;
      pend_rsp_in.rx_level       = udbf_pkg::LEVEL_W'(rx_fill_in);
      pend_rsp_in.tx_level       = udbf_pkg::LEVEL_W'(tx_fill_in);
   end

   always_comb begin
      rsp_data_in = pend_rsp_ff;
      if (pend_pop_ff) begin
         rsp_data_in.data_out = pend_tx_ff ? tx_q : rx_q;
      end
   end

   assign pend_in      = accept || (pend_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         rx_fill_ff   <= '0;
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         tx_fill_ff   <= '0;
         overflow_ff  <= 1'b0;
         rx_irq_ff    <= 1'b1;
         tx_irq_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_wr_ff     <= rx_wr_in;
         rx_rd_ff     <= rx_rd_in;
         rx_fill_ff   <= rx_fill_in;
         tx_wr_ff     <= tx_wr_in;
         tx_rd_ff     <= tx_rd_in;
         tx_fill_ff   <= tx_fill_in;
         overflow_ff  <= overflow_in;
         rx_irq_ff    <= rx_irq_in;
         tx_irq_ff    <= tx_irq_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_pop_ff <= pend_pop_in;
         pend_tx_ff  <= pend_tx_in;
         pend_rsp_ff <= pend_rsp_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   udbf_ram #(
      .WIDTH (udbf_pkg::DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wr_ff),
      .wr_data (req_data.data_in),
      .rd_en   (rx_re),
      .rd_addr (rx_rd_ff),
      .rd_data (rx_q)
   );

   udbf_ram #(
      .WIDTH (udbf_pkg::DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wr_ff),
      .wr_data (req_data.data_in),
      .rd_en   (tx_re),
      .rd_addr (tx_rd_ff),
      .rd_data (tx_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/udbf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UART dual byte FIFO checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "uart_dual_byte_fifo_defines.svh"

module udbf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input udbf_pkg::udbf_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input udbf_pkg::udbf_rsp_type rsp_data
);

   logic req_seen;

   assign req_seen = req_valid && !req_stall && (req_data.req_type == udbf_pkg::EV_LINE_RX);

   `UDBF_ASSERT_ALWAYS(a_reset_no_rsp, reset |=> !rsp_valid)
   `UDBF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `UDBF_ASSERT(a_no_data_on_fail, rsp_valid && rsp_data.status != udbf_pkg::ST_OK |-> rsp_data.data_out == '0)
   `UDBF_ASSERT(a_overflow_sticky, rsp_valid && rsp_data.overflow_seen && !req_seen |=> !rsp_valid || rsp_data.overflow_seen)
   `UDBF_ASSERT(a_irq_off_means_ovf, rsp_valid && !rsp_data.rx_irq_enabled |-> rsp_data.overflow_seen)

endmodule

bind uart_dual_byte_fifo udbf_checker u_udbf_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the UART dual byte FIFO
// Drives line and host events into the block, predicts every response word
// with an in-bench copy of both ring FIFOs and compares each field. Random
// gaps and stalls on both sides, including one long response hold-off.
// ---------------------------------------------------------------------------
module tb;

   localparam int DEPTH           = udbf_pkg::FIFO_DEPTH_DEF;
   localparam int IDX_W           = $clog2(DEPTH);
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int QUIET_LIMIT     = 2000;

   class uart_fifo_tracker;
      logic [udbf_pkg::DATA_W-1:0] rx_mem [DEPTH];
      logic [udbf_pkg::DATA_W-1:0] tx_mem [DEPTH];
      logic [IDX_W-1:0]            rx_wr, rx_rd;
      logic [IDX_W-1:0]            tx_wr, tx_rd;
      int                          rx_fill, tx_fill;
      logic                        overflow, rx_irq, tx_irq;
      udbf_pkg::udbf_rsp_type      expected_words [$];
      int                          mismatches;

      function new();
         rx_wr = '0; rx_rd = '0; rx_fill = 0;
         tx_wr = '0; tx_rd = '0; tx_fill = 0;
         overflow = 1'b0;
         rx_irq = 1'b1;
         tx_irq = 1'b0;
         mismatches = 0;
      endfunction

      function logic [IDX_W-1:0] next_index(logic [IDX_W-1:0] i);
         return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
      endfunction

      function void note_event(udbf_pkg::udbf_req_type w);
         udbf_pkg::udbf_rsp_type e;
         e = '0;
         e.status = udbf_pkg::ST_OK;
         case (w.req_type)
            udbf_pkg::EV_LINE_RX: begin
               if (rx_fill == DEPTH) begin
                  overflow = 1'b1;
                  rx_irq = 1'b0;
                  e.status = udbf_pkg::ST_FULL;
               end else begin
                  rx_mem[rx_wr] = w.data_in;
                  rx_wr = next_index(rx_wr);
                  rx_fill++;
               end
            end
            udbf_pkg::EV_LINE_TX: begin
               if (tx_fill == 0) begin
                  tx_irq = 1'b0;
                  e.status = udbf_pkg::ST_EMPTY;
               end else begin
                  e.data_out = tx_mem[tx_rd];
                  tx_rd = next_index(tx_rd);
                  tx_fill--;
               end
            end
            udbf_pkg::EV_HOST_RD: begin
               if (rx_fill == 0) begin
                  e.status = udbf_pkg::ST_EMPTY;
               end else begin
                  e.data_out = rx_mem[rx_rd];
                  rx_rd = next_index(rx_rd);
                  rx_fill--;
               end
            end
            default: begin
               if (tx_fill == DEPTH) begin
                  e.status = udbf_pkg::ST_FULL;
               end else begin
                  tx_mem[tx_wr] = w.data_in;
                  tx_wr = next_index(tx_wr);
                  tx_fill++;
                  tx_irq = 1'b1;
               end
            end
         endcase
         e.overflow_seen  = overflow;
         e.rx_irq_enabled = rx_irq;
         e.tx_irq_enabled = tx_irq;
         e.rx_level       = udbf_pkg::LEVEL_W'(rx_fill);
         e.tx_level       = udbf_pkg::LEVEL_W'(tx_fill);
         expected_words.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(udbf_pkg::udbf_rsp_type w);
         udbf_pkg::udbf_rsp_type e;
         if (expected_words.size() == 0) begin
            $error("response word with none expected: %h", w);
            mismatches++;
            return;
         end
         e = expected_words.pop_front();
         compare_field("data_out", 32'(e.data_out), 32'(w.data_out));
         compare_field("status", 32'(e.status), 32'(w.status));
         compare_field("overflow_seen", 32'(e.overflow_seen), 32'(w.overflow_seen));
         compare_field("rx_irq_enabled", 32'(e.rx_irq_enabled), 32'(w.rx_irq_enabled));
         compare_field("tx_irq_enabled", 32'(e.tx_irq_enabled), 32'(w.tx_irq_enabled));
         compare_field("rx_level", 32'(e.rx_level), 32'(w.rx_level));
         compare_field("tx_level", 32'(e.tx_level), 32'(w.tx_level));
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   udbf_pkg::udbf_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   udbf_pkg::udbf_rsp_type rsp_data;

   uart_fifo_tracker fifo_model = new();
   int unsigned      words_out = 0;
   int unsigned      quiet_cycles = 0;

   uart_dual_byte_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            fifo_model.note_event(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            fifo_model.check_word(rsp_data);
            words_out <= words_out + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_event(logic [1:0] kind, logic [udbf_pkg::DATA_W-1:0] data);
      udbf_pkg::udbf_req_type w;
      w.req_type = kind;
      w.data_in  = data;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic run_segment(int count, int w_rx_in, int w_tx_out, int w_rd, int w_wr);
      int          r, gap;
      logic [1:0]  kind;
      bit          calm;
      calm = 1'b0;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, w_rx_in + w_tx_out + w_rd + w_wr - 1);
         if (r < w_rx_in) kind = udbf_pkg::EV_LINE_RX;
         else if (r < w_rx_in + w_tx_out) kind = udbf_pkg::EV_LINE_TX;
         else if (r < w_rx_in + w_tx_out + w_rd) kind = udbf_pkg::EV_HOST_RD;
         else kind = udbf_pkg::EV_HOST_WR;
         send_event(kind, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 39) == 0) calm = !calm;
         r = $urandom_range(0, 99);
         if (calm || r < 60) gap = 0;
         else if (r < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 30);
         pause_sender(gap);
      end
   endtask

   initial begin : response_side
      int unsigned r, n;
      bit          calm, held_off;
      calm = 1'b0;
      held_off = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!held_off && words_out >= 60) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            n = HOLD_OFF_CYCLES;
         end else if (calm || r < 65) begin
            rsp_stall <= 1'b0;
            n = 1;
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            n = $urandom_range(8, 25);
         end
         repeat (n) @(negedge clock);
         if ($urandom_range(0, 49) == 0) calm = !calm;
      end
   end

   initial begin : request_side
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_event(udbf_pkg::EV_HOST_RD, 8'h00);
      send_event(udbf_pkg::EV_LINE_TX, 8'hFF);
      send_event(udbf_pkg::EV_LINE_RX, 8'h00);
      send_event(udbf_pkg::EV_LINE_RX, 8'hFF);
      send_event(udbf_pkg::EV_LINE_RX, 8'hA5);
      send_event(udbf_pkg::EV_HOST_WR, 8'hFF);
      send_event(udbf_pkg::EV_HOST_WR, 8'h00);
      send_event(udbf_pkg::EV_HOST_WR, 8'h5A);
      send_event(udbf_pkg::EV_HOST_RD, 8'hFF);
      send_event(udbf_pkg::EV_HOST_RD, 8'h5A);
      send_event(udbf_pkg::EV_HOST_RD, 8'h00);
      send_event(udbf_pkg::EV_HOST_RD, 8'hFF);
      send_event(udbf_pkg::EV_LINE_TX, 8'h00);
      send_event(udbf_pkg::EV_LINE_TX, 8'hAA);
      send_event(udbf_pkg::EV_LINE_TX, 8'h55);
      send_event(udbf_pkg::EV_LINE_TX, 8'h00);
      send_event(udbf_pkg::EV_HOST_WR, 8'h3C);
      send_event(udbf_pkg::EV_LINE_RX, 8'hC3);
      send_event(udbf_pkg::EV_HOST_RD, 8'h81);
      send_event(udbf_pkg::EV_LINE_TX, 8'h7E);

      // Fill the receive side past full, then the transmit side, then drain, then mix.
      run_segment(200, 80, 10, 5, 5);
      run_segment(200, 5, 5, 10, 80);
      run_segment(150, 5, 45, 45, 5);
      run_segment(100, 25, 25, 25, 25);
      pause_sender(1);

      while (fifo_model.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fifo_model.mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
